/* rtl/lbvs_pkg.sv */
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared constants, types and codes of the four-bone linear blend skinner.
// ----------------------------------------------------------------------------
`default_nettype none

package lbvs_pkg;

	localparam int BONE_COUNT  = 256;
	localparam int VALUE_WIDTH = 32;

	localparam int BONE_W    = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
	localparam int ROW_COUNT = BONE_COUNT * 4;
	localparam int ROW_AW    = BONE_W + 2;

	localparam int OP_W   = 2;
	localparam int WORD_W = 32;
	localparam int NRM_W  = 18;
	localparam int WGT_W  = 17;
	localparam int SEL_W  = 32;
	localparam int TEX_W  = 64;
	localparam int INFL   = 4;

	localparam int IN_DATA_W  = 304;
	localparam int OUT_DATA_W = 216;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [18:0] ONE_Q16 = 19'd65536;

	typedef enum logic [1:0] {
		OP_LOAD      = 2'd0,
		OP_SKIN      = 2'd1,
		OP_SKIN_LAST = 2'd2,
		OP_NONE      = 2'd3
	} opcode_t;

	typedef enum logic {
		JOB_LOAD,
		JOB_SKIN
	} job_kind_t;

	typedef struct packed {
		job_kind_t                         kind;
		logic                              last;
		logic [ROW_AW-1:0]                 addr;
		logic [2:0][WORD_W-1:0]            pos;
		logic [2:0][NRM_W-1:0]             nrm;
		logic [INFL-1:0]                   use_bone;
		logic [INFL-1:0][BONE_W-1:0]       bone;
		logic [INFL-1:0][WGT_W-1:0]        weight;
		logic [TEX_W-1:0]                  tex;
	} job_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NEXT,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_WMUL,
		ST_WACC,
		ST_NSHIFT,
		ST_SQ,
		ST_SQACC,
		ST_SQRT,
		ST_DLOAD,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

/* rtl/lbvs_front.sv */
// ----------------------------------------------------------------------------
// lbvs_front
// Accepts requests, decodes the kind and builds the bone influence list.
// ----------------------------------------------------------------------------
`default_nettype none

module lbvs_front (
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [lbvs_pkg::IN_DATA_W-1:0]   s_tdata,
	input  wire logic [lbvs_pkg::OP_W-1:0]        s_tuser,
	input  wire lbvs_pkg::queue_stat_t            q_stat,
	output logic                                  push,
	output lbvs_pkg::job_t                        job
);

	localparam logic [8:0] BONE_LIM = 9'(lbvs_pkg::BONE_COUNT);

	lbvs_pkg::opcode_t                       opcode;
	logic [lbvs_pkg::WGT_W-1:0]              wa, wb, wc;
	logic [lbvs_pkg::SEL_W-1:0]              sel;
	logic [18:0]                             wsum;
	logic [3:0]                              counted;
	logic [3:0]                              in_range;
	logic                                    keep;

	assign opcode = lbvs_pkg::opcode_t'(s_tuser);
	assign wa     = s_tdata[166:150];
	assign wb     = s_tdata[183:167];
	assign wc     = s_tdata[200:184];
	assign sel    = s_tdata[232:201];
	assign wsum   = 19'(wa) + 19'(wb) + 19'(wc);

	// walk stops at first zero weight; fourth bone only on a positive remainder
	assign counted[0] = (wa != '0);
	assign counted[1] = counted[0] && (wb != '0);
	assign counted[2] = counted[1] && (wc != '0);
	assign counted[3] = counted[2] && (wsum < lbvs_pkg::ONE_Q16);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			in_range[i] = ({1'b0, sel[8*i +: 8]} < BONE_LIM);
		end
	end

	always_comb begin
		job.kind   = lbvs_pkg::JOB_SKIN;
		job.last   = (opcode == lbvs_pkg::OP_SKIN_LAST);
		job.addr   = sel[lbvs_pkg::ROW_AW-1:0];
		job.pos[0] = s_tdata[31:0];
		job.pos[1] = s_tdata[63:32];
		job.pos[2] = s_tdata[95:64];
		job.nrm[0] = s_tdata[113:96];
		job.nrm[1] = s_tdata[131:114];
		job.nrm[2] = s_tdata[149:132];
		job.use_bone = counted & in_range;
		for (int i = 0; i < 4; i++) begin
			job.bone[i] = sel[8*i +: lbvs_pkg::BONE_W];
		end
		job.weight[0] = wa;
		job.weight[1] = wb;
		job.weight[2] = wc;
		job.weight[3] = 17'(lbvs_pkg::ONE_Q16 - wsum);
		job.tex       = s_tdata[296:233];
		keep          = 1'b0;
		case (opcode)
			lbvs_pkg::OP_LOAD: begin
				job.kind = lbvs_pkg::JOB_LOAD;
				keep     = (sel[lbvs_pkg::SEL_W-1:2] < 30'(lbvs_pkg::BONE_COUNT));
			end
			lbvs_pkg::OP_SKIN, lbvs_pkg::OP_SKIN_LAST: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

/* rtl/lbvs_queue.sv */
// ----------------------------------------------------------------------------
// lbvs_queue
// Two-entry request queue between the decode front and the compute back.
// ----------------------------------------------------------------------------
`default_nettype none

module lbvs_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire lbvs_pkg::job_t        push_job,
	input  wire logic                  pop,
	output lbvs_pkg::job_t             head_job,
	output lbvs_pkg::queue_stat_t      stat
);

	localparam int PTR_W = (lbvs_pkg::QUEUE_DEPTH > 1) ? $clog2(lbvs_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(lbvs_pkg::QUEUE_DEPTH + 1);

	lbvs_pkg::job_t      slot_q [lbvs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push, do_pop;

	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == CNT_W'(lbvs_pkg::QUEUE_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lbvs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lbvs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/lbvs_back.sv */
// ----------------------------------------------------------------------------
// lbvs_back
// Matrix store, shared multiply-accumulate sequencer, normal renormalization
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbvs_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lbvs_pkg::queue_stat_t            q_stat,
	input  wire lbvs_pkg::job_t                   q_job,
	output logic                                  q_pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [lbvs_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tlast
);

	localparam logic signed [42:0] P_HI =
		43'((64'sd1 <<< (lbvs_pkg::VALUE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [42:0] P_LO = -P_HI - 43'sd1;
	localparam logic signed [49:0] T_HI = 50'sd549755813887;
	localparam logic signed [49:0] T_LO = -50'sd549755813888;

	lbvs_pkg::state_t                 state_q, state_d;
	lbvs_pkg::job_t                   job_q;

	logic [3*lbvs_pkg::WORD_W-1:0]    mem [lbvs_pkg::ROW_COUNT];
	logic [3*lbvs_pkg::WORD_W-1:0]    rdata_q;
	logic [2:0][lbvs_pkg::WORD_W-1:0] rword;
	logic [lbvs_pkg::ROW_AW-1:0]      rd_addr;

	logic [2:0]                       inf_q;
	logic [1:0]                       row_q, col_q;

	logic signed [63:0]               prod_p_s1;
	logic signed [49:0]               prod_n_s1;
	logic signed [49:0]               tacc_q [3];
	logic signed [35:0]               uacc_q [3];
	logic signed [56:0]               wp_s1;
	logic signed [53:0]               wn_s1;
	logic signed [42:0]               pacc_q [3];
	logic signed [38:0]               nacc_q [3];

	logic [38:0]                      mag_q [3];
	logic [2:0]                       neg_q;
	logic [59:0]                      sq_s1;
	logic [63:0]                      rad_q, res_q, sbit_q;
	logic [31:0]                      rem_q;
	logic [16:0]                      nlo_q, quo_q;
	logic [4:0]                       cnt_q;
	logic [2:0][lbvs_pkg::NRM_W-1:0]  nres_q;

	logic                             out_valid_q, out_last_q;
	logic [lbvs_pkg::OUT_DATA_W-1:0]  out_data_q;

	logic                             mem_we, out_load, out_free;
	logic signed [31:0]               m_elem;
	logic signed [31:0]               p_sel;
	logic signed [17:0]               n_sel;
	logic signed [17:0]               w_sel;
	logic signed [63:0]               rp_full;
	logic signed [49:0]               rn_full;
	logic signed [56:0]               rwp_full;
	logic signed [53:0]               rwn_full;
	logic signed [39:0]               t_clamp;
	logic [38:0]                      big;
	logic [63:0]                      rb;
	logic                             rb_ge;
	logic [46:0]                      num;
	logic [31:0]                      rem2;
	logic                             div_ge;
	logic [16:0]                      q_fin;
	logic [2:0][31:0]                 pos_out;

	assign rword   = rdata_q;
	assign rd_addr = {job_q.bone[inf_q[1:0]], row_q};
	assign m_elem  = signed'(rword[col_q]);
	assign p_sel   = (row_q == 2'd3) ? 32'sd0 : signed'(job_q.pos[row_q]);
	assign n_sel   = (row_q == 2'd3) ? 18'sd0 : signed'(job_q.nrm[row_q]);
	assign w_sel   = signed'({1'b0, job_q.weight[inf_q[1:0]]});

	// round half up: add one half lsb, then floor shift
	assign rp_full  = prod_p_s1 + 64'sd32768;
	assign rn_full  = prod_n_s1 + 50'sd32768;
	assign rwp_full = wp_s1 + 57'sd32768;
	assign rwn_full = wn_s1 + 54'sd32768;

	always_comb begin
		if (tacc_q[col_q] > T_HI) begin
			t_clamp = T_HI[39:0];
		end else if (tacc_q[col_q] < T_LO) begin
			t_clamp = T_LO[39:0];
		end else begin
			t_clamp = tacc_q[col_q][39:0];
		end
	end

	always_comb begin
		big = mag_q[0];
		if (mag_q[1] > big) begin
			big = mag_q[1];
		end
		if (mag_q[2] > big) begin
			big = mag_q[2];
		end
	end

	assign rb     = res_q + sbit_q;
	assign rb_ge  = (rad_q >= rb);
	assign num    = {1'b0, mag_q[col_q][29:0], 16'b0} + 47'(res_q[31:1]);
	assign rem2   = {rem_q[30:0], nlo_q[16]};
	assign div_ge = (rem2 >= res_q[31:0]);
	assign q_fin  = {quo_q[15:0], div_ge};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (pacc_q[c] > P_HI) begin
				pos_out[c] = P_HI[31:0];
			end else if (pacc_q[c] < P_LO) begin
				pos_out[c] = P_LO[31:0];
			end else begin
				pos_out[c] = pacc_q[c][31:0];
			end
		end
	end

	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lbvs_pkg::ST_IDLE: begin
				if (q_stat.valid && q_job.kind == lbvs_pkg::JOB_SKIN) begin
					state_d = lbvs_pkg::ST_NEXT;
				end
			end
			lbvs_pkg::ST_NEXT: begin
				if (inf_q == 3'd4) begin
					state_d = lbvs_pkg::ST_NSHIFT;
				end else if (job_q.use_bone[inf_q[1:0]]) begin
					state_d = lbvs_pkg::ST_READ;
				end
			end
			lbvs_pkg::ST_READ: state_d = lbvs_pkg::ST_MUL;
			lbvs_pkg::ST_MUL:  state_d = lbvs_pkg::ST_ACC;
			lbvs_pkg::ST_ACC: begin
				if (col_q != 2'd2) begin
					state_d = lbvs_pkg::ST_MUL;
				end else if (row_q != 2'd3) begin
					state_d = lbvs_pkg::ST_READ;
				end else begin
					state_d = lbvs_pkg::ST_WMUL;
				end
			end
			lbvs_pkg::ST_WMUL: state_d = lbvs_pkg::ST_WACC;
			lbvs_pkg::ST_WACC: begin
				state_d = (col_q == 2'd2) ? lbvs_pkg::ST_NEXT : lbvs_pkg::ST_WMUL;
			end
			lbvs_pkg::ST_NSHIFT: begin
				if (big == '0) begin
					state_d = lbvs_pkg::ST_OUT;
				end else if (big[38:30] == '0 && big[29]) begin
					state_d = lbvs_pkg::ST_SQ;
				end
			end
			lbvs_pkg::ST_SQ: state_d = lbvs_pkg::ST_SQACC;
			lbvs_pkg::ST_SQACC: begin
				state_d = (col_q == 2'd2) ? lbvs_pkg::ST_SQRT : lbvs_pkg::ST_SQ;
			end
			lbvs_pkg::ST_SQRT: begin
				if (sbit_q == 64'd1) begin
					state_d = lbvs_pkg::ST_DLOAD;
				end
			end
			lbvs_pkg::ST_DLOAD: state_d = lbvs_pkg::ST_DIV;
			lbvs_pkg::ST_DIV: begin
				if (cnt_q == 5'd1) begin
					state_d = (col_q == 2'd2) ? lbvs_pkg::ST_OUT : lbvs_pkg::ST_DLOAD;
				end
			end
			lbvs_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = lbvs_pkg::ST_IDLE;
				end
			end
			default: state_d = lbvs_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			lbvs_pkg::ST_IDLE: begin
				q_pop  = q_stat.valid;
				mem_we = q_stat.valid && q_job.kind == lbvs_pkg::JOB_LOAD;
			end
			lbvs_pkg::ST_OUT: begin
				out_load = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_job.addr] <= {q_job.pos[2], q_job.pos[1], q_job.pos[0]};
		end
		if (state_q == lbvs_pkg::ST_READ) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbvs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lbvs_pkg::ST_IDLE: begin
				job_q <= q_job;
				inf_q <= '0;
				for (int c = 0; c < 3; c++) begin
					pacc_q[c] <= '0;
					nacc_q[c] <= '0;
				end
			end
			lbvs_pkg::ST_NEXT: begin
				row_q <= '0;
				col_q <= '0;
				for (int c = 0; c < 3; c++) begin
					tacc_q[c] <= '0;
					uacc_q[c] <= '0;
					mag_q[c]  <= nacc_q[c][38] ? 39'(-nacc_q[c]) : 39'(nacc_q[c]);
					neg_q[c]  <= nacc_q[c][38];
				end
				if (inf_q != 3'd4 && !job_q.use_bone[inf_q[1:0]]) begin
					inf_q <= inf_q + 3'd1;
				end
			end
			lbvs_pkg::ST_READ: begin
				col_q <= '0;
			end
			lbvs_pkg::ST_MUL: begin
				prod_p_s1 <= p_sel * m_elem;
				prod_n_s1 <= 50'(n_sel * m_elem);
			end
			lbvs_pkg::ST_ACC: begin
				if (row_q == 2'd3) begin
					tacc_q[col_q] <= tacc_q[col_q] + 50'(m_elem);
				end else begin
					tacc_q[col_q] <= tacc_q[col_q] + 50'(signed'(rp_full[63:16]));
					uacc_q[col_q] <= uacc_q[col_q] + 36'(signed'(rn_full[49:16]));
				end
				if (col_q != 2'd2) begin
					col_q <= col_q + 2'd1;
				end else begin
					col_q <= '0;
					row_q <= row_q + 2'd1;
				end
			end
			lbvs_pkg::ST_WMUL: begin
				wp_s1 <= 57'(t_clamp * w_sel);
				wn_s1 <= 54'(uacc_q[col_q] * w_sel);
			end
			lbvs_pkg::ST_WACC: begin
				pacc_q[col_q] <= pacc_q[col_q] + 43'(signed'(rwp_full[56:16]));
				nacc_q[col_q] <= nacc_q[col_q] + 39'(signed'(rwn_full[53:16]));
				if (col_q == 2'd2) begin
					inf_q <= inf_q + 3'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
			lbvs_pkg::ST_NSHIFT: begin
				col_q <= '0;
				rad_q <= '0;
				if (big == '0) begin
					nres_q <= '0;
				end else if (big[38:30] != '0) begin
					for (int c = 0; c < 3; c++) begin
						mag_q[c] <= mag_q[c] >> 1;
					end
				end else if (!big[29]) begin
					for (int c = 0; c < 3; c++) begin
						mag_q[c] <= mag_q[c] << 1;
					end
				end
			end
			lbvs_pkg::ST_SQ: begin
				sq_s1 <= mag_q[col_q][29:0] * mag_q[col_q][29:0];
			end
			lbvs_pkg::ST_SQACC: begin
				rad_q  <= rad_q + 64'(sq_s1);
				res_q  <= '0;
				sbit_q <= 64'd1 << 62;
				col_q  <= (col_q == 2'd2) ? 2'd0 : col_q + 2'd1;
			end
			lbvs_pkg::ST_SQRT: begin
				if (rb_ge) begin
					rad_q <= rad_q - rb;
					res_q <= (res_q >> 1) + sbit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			lbvs_pkg::ST_DLOAD: begin
				rem_q <= 32'(num[46:17]);
				nlo_q <= num[16:0];
				quo_q <= '0;
				cnt_q <= 5'd17;
			end
			lbvs_pkg::ST_DIV: begin
				rem_q <= div_ge ? rem2 - res_q[31:0] : rem2;
				nlo_q <= nlo_q << 1;
				quo_q <= q_fin;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					nres_q[col_q] <= neg_q[col_q] ? 18'(-{1'b0, q_fin}) : 18'({1'b0, q_fin});
					col_q <= col_q + 2'd1;
				end
			end
			lbvs_pkg::ST_OUT: begin
				if (out_load) begin
					out_data_q <= {2'b0, job_q.tex, nres_q[2], nres_q[1], nres_q[0],
						pos_out[2], pos_out[1], pos_out[0]};
					out_last_q <= job_q.last;
				end
			end
			default: begin
				col_q <= col_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

/* rtl/linear_blend_vertex_skinning_top.sv */
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// Four-bone linear blend vertex skinner with a Q16.16 bone matrix store.
//
// Input stream s_*: tuser carries the opcode (load row, skin, skin last),
// tdata the position or matrix row, normal, weights, bone bytes and texcoords.
// Output stream m_*: one result per vertex, tlast marks the last of a mesh.
// A load is absorbed by the back end while it is idle and gives no result.
// A vertex passes each used bone's matrix elements through the shared
// multiply-accumulate pair, then a shift search, three squares, a 32-step
// square root and three 17-step divides for the unit normal.
// A two-entry queue lets the front keep taking requests while the back
// works; s_tready drops only when that queue is full.
// When m_tready is low the finished result holds in the output register and
// the back end waits before loading its next result into it.
// Reset clears the queue, the sequencer and the output valid; the matrix
// store is not cleared and must be loaded before vertices use it.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_blend_vertex_skinning_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, weight_a, weight_b, weight_c,
	// bone_select, texcoord_pair, zero pad
	input  wire logic [lbvs_pkg::IN_DATA_W-1:0]   s_tdata,
	// opcode
	input  wire logic [lbvs_pkg::OP_W-1:0]        s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z,
	// out_texcoord_pair, zero pad
	output logic [lbvs_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tlast
);

	lbvs_pkg::queue_stat_t q_stat;
	lbvs_pkg::job_t        push_job, head_job;
	logic                  push, pop;

	lbvs_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.job      (push_job)
	);

	lbvs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	lbvs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_job    (head_job),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

/* rtl/lbvs_checker.sv */
// ----------------------------------------------------------------------------
// lbvs_checker
// Port-level checks of the skinner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbvs_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	input  wire logic [lbvs_pkg::IN_DATA_W-1:0]   s_tdata,
	input  wire logic [lbvs_pkg::OP_W-1:0]        s_tuser,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	input  wire logic [lbvs_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  wire logic                             m_tlast
);

	logic signed [17:0] nx, ny, nz;

	assign nx = signed'(m_tdata[113:96]);
	assign ny = signed'(m_tdata[131:114]);
	assign nz = signed'(m_tdata[149:132]);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("request changed while waiting");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_unit_nrm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> nx >= -18'sd65536 && nx <= 18'sd65536 &&
			ny >= -18'sd65536 && ny <= 18'sd65536 &&
			nz >= -18'sd65536 && nz <= 18'sd65536)
		else $error("normal component beyond unit range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[215:214] == 2'b00)
		else $error("output pad bits not zero");

endmodule

bind linear_blend_vertex_skinning_top lbvs_checker u_lbvs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-bone linear blend vertex skinner: matrix
// rows are loaded, vertices are skinned by an in-bench predictor, and every
// result on the output stream is compared field by field, under sender and
// receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	typedef struct packed {
		logic [63:0]       tex;
		logic [31:0]       sel;
		logic [2:0][16:0]  wgt;
		logic [2:0][17:0]  nrm;
		logic [2:0][31:0]  pos;
	} skin_req_t;

	typedef struct packed {
		logic              last;
		logic [63:0]       tex;
		logic [2:0][17:0]  nrm;
		logic [2:0][31:0]  pos;
	} skinned_vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [lbvs_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [lbvs_pkg::OP_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lbvs_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;

	logic [31:0] bone_mat [0:lbvs_pkg::BONE_COUNT*12-1];
	logic [3:0] rows_loaded [0:lbvs_pkg::BONE_COUNT-1];
	int ready_bones[$];
	skinned_vertex_t pending_vertices[$];
	longint acc_pos [3];
	longint acc_nrm [3];

	int send_idle = 0;
	int recv_idle = 0;
	int fail_count = 0;
	int n_vertices = 0;
	int n_loads = 0;
	int n_dropped = 0;
	int n_fourth = 0;
	int n_checked = 0;

	always #6 clk = ~clk;

	linear_blend_vertex_skinning_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	function automatic longint round_q16(longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	function automatic longint mat_at(int bone, int row, int col);
		return longint'($signed(bone_mat[(bone * 4 + row) * 3 + col]));
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic void blend_bone(int bone, longint w, longint p[3], longint n[3]);
		longint t, u;
		if (bone >= lbvs_pkg::BONE_COUNT)
			return;
		for (int c = 0; c < 3; c++) begin
			t = mat_at(bone, 3, c);
			u = 0;
			for (int r = 0; r < 3; r++) begin
				t += round_q16(p[r] * mat_at(bone, r, c));
				u += round_q16(n[r] * mat_at(bone, r, c));
			end
			if (t < -(64'sd1 <<< 39))
				t = -(64'sd1 <<< 39);
			if (t > (64'sd1 <<< 39) - 1)
				t = (64'sd1 <<< 39) - 1;
			acc_pos[c] += round_q16(t * w);
			acc_nrm[c] += round_q16(u * w);
		end
	endfunction

	function automatic skinned_vertex_t skin_vertex(skin_req_t r, logic last);
		skinned_vertex_t res;
		longint p[3], n[3], total, q;
		logic [63:0] mag[3], big, sum, len;
		int j;
		for (int c = 0; c < 3; c++) begin
			p[c] = longint'($signed(r.pos[c]));
			n[c] = longint'($signed(r.nrm[c]));
			acc_pos[c] = 0;
			acc_nrm[c] = 0;
		end
		total = 0;
		j = 0;
		while (j < 3 && r.wgt[j] != 0) begin
			blend_bone(int'(r.sel[j*8 +: 8]), longint'(r.wgt[j]), p, n);
			total += longint'(r.wgt[j]);
			j++;
		end
		if (j == 3 && 65536 - total > 0) begin
			blend_bone(int'(r.sel[31:24]), 65536 - total, p, n);
			n_fourth++;
		end
		big = 0;
		for (int c = 0; c < 3; c++) begin
			mag[c] = acc_nrm[c] < 0 ? 64'(-acc_nrm[c]) : 64'(acc_nrm[c]);
			if (mag[c] > big)
				big = mag[c];
		end
		if (big == 0) begin
			res.nrm = '0;
		end else begin
			while (big >= (64'd1 << 30)) begin
				big = big >> 1;
				for (int c = 0; c < 3; c++)
					mag[c] = mag[c] >> 1;
			end
			while (big < (64'd1 << 29)) begin
				big = big << 1;
				for (int c = 0; c < 3; c++)
					mag[c] = mag[c] << 1;
			end
			sum = 0;
			for (int c = 0; c < 3; c++)
				sum += mag[c] * mag[c];
			len = isqrt(sum);
			for (int c = 0; c < 3; c++) begin
				q = longint'((mag[c] * 64'd65536 + len / 2) / len);
				res.nrm[c] = acc_nrm[c] < 0 ? 18'(-q) : 18'(q);
			end
		end
		for (int c = 0; c < 3; c++) begin
			if (acc_pos[c] > 64'sd2147483647)
				res.pos[c] = 32'h7fffffff;
			else if (acc_pos[c] < -64'sd2147483648)
				res.pos[c] = 32'h80000000;
			else
				res.pos[c] = 32'(acc_pos[c]);
		end
		res.tex = r.tex;
		res.last = last;
		return res;
	endfunction

	// bookkeeping at the moment a request is accepted
	function automatic void take_request(lbvs_pkg::opcode_t op, skin_req_t r);
		int bone;
		case (op)
			lbvs_pkg::OP_LOAD: begin
				if ((r.sel >> 2) < lbvs_pkg::BONE_COUNT) begin
					bone = int'(r.sel >> 2);
					for (int c = 0; c < 3; c++)
						bone_mat[(bone * 4 + int'(r.sel[1:0])) * 3 + c] = r.pos[c];
					if (rows_loaded[bone] != 4'hf) begin
						rows_loaded[bone][r.sel[1:0]] = 1'b1;
						if (rows_loaded[bone] == 4'hf)
							ready_bones.push_back(bone);
					end
					n_loads++;
				end else begin
					n_dropped++;
				end
			end
			lbvs_pkg::OP_SKIN, lbvs_pkg::OP_SKIN_LAST: begin
				pending_vertices.push_back(skin_vertex(r, op == lbvs_pkg::OP_SKIN_LAST));
				n_vertices++;
			end
			default: n_dropped++;
		endcase
	endfunction

	task automatic send_request(lbvs_pkg::opcode_t op, skin_req_t r);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(lbvs_pkg::IN_DATA_W - $bits(skin_req_t)){1'b0}}, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		take_request(op, r);
		@(negedge clk);
	endtask

	task automatic wait_all_done();
		s_tvalid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic skin_req_t random_fields();
		skin_req_t r;
		for (int c = 0; c < 3; c++) begin
			r.pos[c] = $urandom;
			r.nrm[c] = 18'($signed($urandom_range(0, 131072)) - 65536);
			r.wgt[c] = 17'($urandom_range(0, 65536));
		end
		r.sel = $urandom;
		r.tex = {$urandom, $urandom};
		return r;
	endfunction

	function automatic logic [31:0] random_entry();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 262143)) - 131072);
			default: return 32'($signed($urandom_range(0, 4194303)) - 2097152);
		endcase
	endfunction

	task automatic load_row(int bone, int row, logic [31:0] e0, logic [31:0] e1,
			logic [31:0] e2);
		skin_req_t r;
		r = random_fields();
		r.sel = 32'(bone * 4 + row);
		r.pos[0] = e0;
		r.pos[1] = e1;
		r.pos[2] = e2;
		send_request(lbvs_pkg::OP_LOAD, r);
	endtask

	task automatic skin_request(logic [2:0][16:0] w, logic [31:0] sel,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [17:0] nx, logic [17:0] ny, logic [17:0] nz, logic last);
		skin_req_t r;
		r = random_fields();
		r.wgt = w;
		r.sel = sel;
		r.pos[0] = px;
		r.pos[1] = py;
		r.pos[2] = pz;
		r.nrm[0] = nx;
		r.nrm[1] = ny;
		r.nrm[2] = nz;
		send_request(last ? lbvs_pkg::OP_SKIN_LAST : lbvs_pkg::OP_SKIN, r);
	endtask

	task automatic test_matrix_load();
		load_row(0, 0, 32'h10000, 0, 0);
		load_row(0, 1, 0, 32'h10000, 0);
		load_row(0, 2, 0, 0, 32'h10000);
		load_row(0, 3, 32'h18000, 32'hfffe0000, 0);
		load_row(255, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		load_row(255, 1, 32'h80000000, 32'h7fffffff, 32'h80000000);
		load_row(255, 2, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		load_row(255, 3, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		load_row(1, 0, random_entry(), random_entry(), random_entry());
		load_row(1, 1, random_entry(), random_entry(), random_entry());
		load_row(1, 2, random_entry(), random_entry(), random_entry());
		load_row(1, 3, random_entry(), random_entry(), random_entry());
	endtask

	task automatic test_directed_vertices();
		// single bone, full weight
		skin_request({17'd0, 17'd0, 17'd65536}, 32'h0, 32'h30000, 32'hfffd0000, 32'h8000,
			18'd65536, 18'd0, 18'd0, 1'b0);
		// extreme positions through the extreme matrix, saturating
		skin_request({17'd0, 17'd0, 17'd65536}, 32'hff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 18'd65536, 18'd65536, 18'd65536, 1'b0);
		skin_request({17'd0, 17'd0, 17'd65536}, 32'hff, 32'h80000000, 32'h80000000,
			32'h80000000, 18'h30000, 18'h30000, 18'h30000, 1'b0);
		// first weight zero, nothing blended
		skin_request({17'd5000, 17'd7000, 17'd0}, 32'hffffffff, 32'h12345, 32'h1, 32'h2,
			18'd100, 18'd0, 18'd0, 1'b0);
		// three weights below one, fourth bone takes the rest
		skin_request({17'd10000, 17'd20000, 17'd15000}, 32'h01ff0100, 32'h20000,
			32'h10000, 32'hffff0000, 18'd0, 18'd65536, 18'h30000, 1'b0);
		// weights summing above one, no fourth bone
		skin_request({17'd65536, 17'd65536, 17'd65536}, 32'h00010100, 32'h4000, 32'h5000,
			32'h6000, 18'd30000, 18'd40000, 18'd0, 1'b0);
		// walk stops at the zero in the middle
		skin_request({17'd30000, 17'd0, 17'd40000}, 32'h0000ff01, 32'h10000, 32'h10000,
			32'h10000, 18'd1, 18'd1, 18'd1, 1'b0);
		// zero source normal
		skin_request({17'd0, 17'd32768, 17'd32768}, 32'h00000100, 32'h7000, 32'h0, 32'h0,
			18'd0, 18'd0, 18'd0, 1'b0);
		skin_request({17'd0, 17'd0, 17'd65536}, 32'h01, 32'h1, 32'hffffffff, 32'h0,
			18'h30000, 18'd65536, 18'd0, 1'b1);
	endtask

	task automatic test_ignored_items();
		skin_req_t r;
		r = random_fields();
		send_request(lbvs_pkg::OP_NONE, r);
		r = random_fields();
		r.sel = 32'h400;
		send_request(lbvs_pkg::OP_LOAD, r);
		r = random_fields();
		r.sel = 32'h80000000;
		send_request(lbvs_pkg::OP_LOAD, r);
	endtask

	task automatic test_random_mesh(int count);
		skin_req_t r;
		int pick, bone, used;
		longint total;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			r = random_fields();
			if (pick < 3) begin
				send_request(lbvs_pkg::OP_NONE, r);
			end else if (pick < 6) begin
				r.sel[31:10] = 22'($urandom_range(1, 32'h3fffff));
				send_request(lbvs_pkg::OP_LOAD, r);
			end else if (pick < 14) begin
				bone = $urandom_range(0, lbvs_pkg::BONE_COUNT - 1);
				for (int row = 0; row < 4; row++)
					load_row(bone, row, random_entry(), random_entry(), random_entry());
				i += 3;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5:
						for (int c = 0; c < 3; c++)
							r.wgt[c] = 17'($urandom_range(1, 24000));
					6, 7: ;
					8: r.wgt = {17'd65536, 17'd65536, 17'd65536};
					default:
						r.wgt[$urandom_range(0, 2)] = 17'd0;
				endcase
				used = 0;
				total = 0;
				while (used < 3 && r.wgt[used] != 0) begin
					total += longint'(r.wgt[used]);
					used++;
				end
				if (used == 3 && 65536 - total > 0)
					used = 4;
				for (int k = 0; k < used; k++)
					r.sel[k*8 +: 8] = 8'(ready_bones[$urandom_range(0, ready_bones.size() - 1)]);
				send_request($urandom_range(0, 9) == 0 ? lbvs_pkg::OP_SKIN_LAST
					: lbvs_pkg::OP_SKIN, r);
			end
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk) begin
		skinned_vertex_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pos = m_tdata[95:0];
			got.nrm = m_tdata[149:96];
			got.tex = m_tdata[213:150];
			got.last = m_tlast;
			if (pending_vertices.size() == 0) begin
				$display("%0t unexpected result %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = pending_vertices.pop_front();
				n_checked++;
				for (int c = 0; c < 3; c++) begin
					if (got.pos[c] !== want.pos[c]) begin
						$display("%0t pos[%0d] expected %h got %h", $time, c, want.pos[c],
							got.pos[c]);
						fail_count++;
					end
					if (got.nrm[c] !== want.nrm[c]) begin
						$display("%0t nrm[%0d] expected %h got %h", $time, c, want.nrm[c],
							got.nrm[c]);
						fail_count++;
					end
				end
				if (got.tex !== want.tex) begin
					$display("%0t texcoord expected %h got %h", $time, want.tex, got.tex);
					fail_count++;
				end
				if (got.last !== want.last) begin
					$display("%0t last expected %b got %b", $time, want.last, got.last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#(12 * 3_000_000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		for (int b = 0; b < lbvs_pkg::BONE_COUNT; b++)
			rows_loaded[b] = 4'h0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle = 28;
		recv_idle = 77;
		test_matrix_load();
		test_directed_vertices();
		test_ignored_items();
		wait_all_done();
		test_random_mesh(540);
		wait_all_done();
		send_idle = 77;
		recv_idle = 28;
		test_random_mesh(540);
		wait_all_done();
		send_idle = 0;
		recv_idle = 0;
		test_random_mesh(540);
		wait_all_done();
		$display("covered %0d vertices (%0d with a fourth bone), %0d matrix rows loaded",
			n_vertices, n_fourth, n_loads);
		$display("%0d results checked, %0d ignored requests, %0d mismatches",
			n_checked, n_dropped, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* linear_blend_vertex_skinning_top.f */
rtl/lbvs_pkg.sv
rtl/lbvs_front.sv
rtl/lbvs_queue.sv
rtl/lbvs_back.sv
rtl/linear_blend_vertex_skinning_top.sv
rtl/lbvs_checker.sv
sim/testbench.sv
